// ===== rtl/feistel_block_cipher_cbc_macros.svh =====
// Assertion macros used by the checker file of the Feistel CBC block.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef FEISTEL_BLOCK_CIPHER_CBC_MACROS_SVH
`define FEISTEL_BLOCK_CIPHER_CBC_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FBC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fbc assertion failed");

// Next-cycle implication, checked outside reset.
`define FBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fbc assertion failed");

`endif

// ===== rtl/fbc_pkg.sv =====
// Package of the Feistel CBC block: item modes, key word layout and the LFSR step.
// No dependencies.
package fbc_pkg;

    typedef enum logic [1:0] {
        MODE_KEY = 2'd0,
        MODE_IV  = 2'd1,
        MODE_ENC = 2'd2,
        MODE_DEC = 2'd3
    } t_mode;

    localparam int NUM_SBOXES    = 8;
    localparam int SBOX_ENTRIES  = 256;
    localparam int PERM_ENTRIES  = 8;
    localparam int PERM_SEED_IDX = NUM_SBOXES;
    localparam int RK_BASE       = NUM_SBOXES + 1;

    // Eight steps of the 32-bit Galois-free shift register, taps 31,6,4,2,1,0.
    function automatic logic [31:0] lfsr_step8(input logic [31:0] s_in);
        logic [31:0] s;
        logic        fb;
        s = s_in;
        for (int k = 0; k < 8; k++) begin
            fb = s[31] ^ s[6] ^ s[4] ^ s[2] ^ s[1] ^ s[0];
            s  = {fb, s[31:1]};
        end
        return s;
    endfunction

endpackage

// ===== rtl/fbc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module fbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/feistel_block_cipher_cbc.sv =====
// Top level of the 128-bit Feistel block cipher with CBC chaining.
// Depends on fbc_pkg and fbc_ram.
//
// Usage:
//   The input channel (i_in_valid / o_in_ready) carries one item per transfer:
//   a key word load, a chain IV load, an encrypt block or a decrypt block.
//   The output channel (o_out_valid / i_out_ready) returns exactly one result
//   per item: the block for encrypt and decrypt, zero words for loads, and
//   o_status high when a key word index is out of range.
//   The block works on one item at a time. An encrypt or decrypt passes,
//   for each round, through a read state (ST_RND_RD) that reads the eight
//   S-box banks and the round key RAMs and a mixing state (ST_RND_EX); a
//   finishing state (ST_FINISH) then moves the result to the output
//   register, and the block returns to idle before it takes the next item.
//   Round key, whitening, IV and out-of-range loads go from the transfer
//   straight to the finishing state.
//   A seed load rebuilds an S-box or the permutation by shuffling a list held
//   in a RAM: each draw steps the LFSR, reduces the drawn byte by a bit-serial
//   modulo, stores the picked entry and removes it by shifting the rest of the
//   list down one entry at a time.
//   Reset clears the chain value, the LFSR, the sequencer state and the
//   output valid flag; key material is undefined until loaded. A finished
//   result waits in the output register while the receiver stalls; the
//   next item is taken once the current result has been placed there.
module feistel_block_cipher_cbc #(
    parameter int NUM_ROUNDS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [5:0]  i_key_index,
    input  logic [31:0] i_word0,
    input  logic [31:0] i_word1,
    input  logic [31:0] i_word2,
    input  logic [31:0] i_word3,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_out_word0,
    output logic [31:0] o_out_word1,
    output logic [31:0] o_out_word2,
    output logic [31:0] o_out_word3,
    output logic        o_status
);
    import fbc_pkg::*;

    localparam int RKAW      = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;
    localparam int WK_BASE   = RK_BASE + 2 * NUM_ROUNDS;
    localparam int KEY_WORDS = WK_BASE + 8;

    typedef enum logic [3:0] {
        ST_IDLE, ST_INIT, ST_DRAW, ST_DIV, ST_PRD, ST_PWR,
        ST_SRD, ST_SWR, ST_RND_RD, ST_RND_EX, ST_FINISH
    } t_state;

    t_state      r_state;
    logic        r_dec;
    logic        r_to_perm;
    logic [2:0]  r_sidx;
    logic [8:0]  r_n;
    logic [8:0]  r_i;
    logic [8:0]  r_cnt;
    logic [8:0]  r_acc;
    logic [7:0]  r_byte;
    logic [7:0]  r_pick;
    logic [7:0]  r_k;
    logic [31:0] r_lfsr;
    logic [31:0] r_w     [4];
    logic [31:0] r_in    [4];
    logic [31:0] r_chain [4];
    logic [31:0] r_wk    [8];
    logic [31:0] r_res   [4];
    logic [2:0]  r_perm  [8];
    logic [RKAW-1:0] r_round;
    logic        r_res_status;
    logic        r_out_valid;
    logic [31:0] r_out   [4];
    logic        r_status;

    logic        in_fire;
    logic [31:0] in_w [4];
    logic [6:0]  idx7;
    logic [6:0]  rk_rel;
    logic [6:0]  wk_rel;
    logic        rk_we;
    logic [8:0]  rem;
    logic [8:0]  acc_sh;
    logic [8:0]  acc_nx;
    logic [8:0]  i_nx;
    logic [8:0]  k_nx;
    logic [RKAW-1:0] kr;
    logic [7:0]  list_rdata;
    logic        list_we;
    logic [7:0]  list_waddr;
    logic [7:0]  list_wdata;
    logic [7:0]  list_raddr;
    logic [7:0]  sb_rd    [8];
    logic [7:0]  sb_raddr [8];
    logic        sb_we    [8];
    logic [31:0] rk_even;
    logic [31:0] rk_odd;
    logic [7:0]  pb [8];
    logic [31:0] pa;
    logic [31:0] pbw;
    logic [31:0] t0;
    logic [31:0] t1;
    logic        out_slot;

    assign in_fire  = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_w[0] = i_word0;
    assign in_w[1] = i_word1;
    assign in_w[2] = i_word2;
    assign in_w[3] = i_word3;
    assign idx7    = {1'b0, i_key_index};
    assign rk_rel  = idx7 - 7'(RK_BASE);
    assign wk_rel  = idx7 - 7'(WK_BASE);
    assign rk_we   = in_fire && (t_mode'(i_mode) == MODE_KEY)
                     && (idx7 >= 7'(RK_BASE)) && (idx7 < 7'(WK_BASE));
    assign rem     = r_n - r_i;
    assign i_nx    = r_i + 9'd1;
    assign k_nx    = {1'b0, r_k} + 9'd1;
    assign kr      = r_dec ? (RKAW'(NUM_ROUNDS - 1) - r_round) : r_round;
    assign out_slot = !r_out_valid || i_out_ready;

    // Remainder step of the draw-modulo-count divider, one bit per cycle.
    always_comb begin
        acc_sh = {r_acc[7:0], r_byte[7]};
        acc_nx = (acc_sh >= rem) ? (acc_sh - rem) : acc_sh;
    end

    // Shuffle list RAM control.
    always_comb begin
        list_we    = 1'b0;
        list_waddr = r_cnt[7:0];
        list_wdata = r_cnt[7:0];
        list_raddr = r_pick;
        case (r_state)
            ST_INIT: begin
                list_we = 1'b1;
            end
            ST_SRD: begin
                list_raddr = k_nx[7:0];
            end
            ST_SWR: begin
                list_we    = 1'b1;
                list_waddr = r_k;
                list_wdata = list_rdata;
            end
            default: begin
                list_we = 1'b0;
            end
        endcase
    end

    fbc_ram #(.WIDTH(8), .DEPTH(SBOX_ENTRIES)) u_list (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (list_waddr),
        .i_wdata (list_wdata),
        .i_raddr (list_raddr),
        .o_rdata (list_rdata)
    );

    // S-box store, one bank per S-box so a round reads all eight at once.
    for (genvar g = 0; g < NUM_SBOXES; g++) begin : g_sbox
        assign sb_raddr[g] = (g < 4) ? r_w[2][8*(g%4) +: 8] : r_w[3][8*(g%4) +: 8];
        assign sb_we[g]    = (r_state == ST_PWR) && !r_to_perm && (r_sidx == 3'(g));
        fbc_ram #(.WIDTH(8), .DEPTH(SBOX_ENTRIES)) u_bank (
            .i_clk   (i_clk),
            .i_we    (sb_we[g]),
            .i_waddr (r_i[7:0]),
            .i_wdata (list_rdata),
            .i_raddr (sb_raddr[g]),
            .o_rdata (sb_rd[g])
        );
    end

    // Round keys: even keys and odd keys in separate RAMs.
    fbc_ram #(.WIDTH(32), .DEPTH(NUM_ROUNDS)) u_rk_even (
        .i_clk   (i_clk),
        .i_we    (rk_we && !rk_rel[0]),
        .i_waddr (rk_rel[RKAW:1]),
        .i_wdata (i_word0),
        .i_raddr (kr),
        .o_rdata (rk_even)
    );

    fbc_ram #(.WIDTH(32), .DEPTH(NUM_ROUNDS)) u_rk_odd (
        .i_clk   (i_clk),
        .i_we    (rk_we && rk_rel[0]),
        .i_waddr (rk_rel[RKAW:1]),
        .i_wdata (i_word0),
        .i_raddr (kr),
        .o_rdata (rk_odd)
    );

    // Round function: permute S-box outputs (later bytes win), PHT, round keys.
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            pb[b] = 8'd0;
        end
        for (int b = 0; b < 8; b++) begin
            pb[r_perm[b]] = sb_rd[b];
        end
        pa  = {pb[3], pb[2], pb[1], pb[0]};
        pbw = {pb[7], pb[6], pb[5], pb[4]};
        t0  = ((pa + pbw) ^ rk_even) ^ r_w[0];
        t1  = ((pa + {pbw[30:0], 1'b0}) ^ rk_odd) ^ r_w[1];
    end

    // Main sequencer with its registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_lfsr      <= 32'd0;
            for (int j = 0; j < 4; j++) begin
                r_chain[j] <= 32'd0;
            end
        end else begin
            if (r_out_valid && i_out_ready && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_res_status <= (t_mode'(i_mode) == MODE_KEY)
                                        && (idx7 >= 7'(KEY_WORDS));
                        for (int j = 0; j < 4; j++) begin
                            r_res[j] <= 32'd0;
                        end
                        r_dec     <= (t_mode'(i_mode) == MODE_DEC);
                        r_to_perm <= (idx7 == 7'(PERM_SEED_IDX));
                        r_sidx    <= i_key_index[2:0];
                        r_cnt     <= 9'd0;
                        r_i       <= 9'd0;
                        r_round   <= '0;
                        case (t_mode'(i_mode))
                            MODE_KEY: begin
                                if (idx7 >= 7'(KEY_WORDS)) begin
                                    r_state      <= ST_FINISH;
                                end else if (idx7 <= 7'(PERM_SEED_IDX)) begin
                                    r_lfsr  <= i_word0;
                                    r_n     <= (idx7 == 7'(PERM_SEED_IDX))
                                               ? 9'(PERM_ENTRIES) : 9'(SBOX_ENTRIES);
                                    r_state <= ST_INIT;
                                end else begin
                                    if (idx7 >= 7'(WK_BASE)) begin
                                        r_wk[wk_rel[2:0]] <= i_word0;
                                    end
                                    r_state <= ST_FINISH;
                                end
                            end
                            MODE_IV: begin
                                for (int j = 0; j < 4; j++) begin
                                    r_chain[j] <= in_w[j];
                                end
                                r_state <= ST_FINISH;
                            end
                            MODE_ENC: begin
                                for (int j = 0; j < 4; j++) begin
                                    r_in[j] <= in_w[j];
                                    r_w[j]  <= in_w[j] ^ r_chain[j] ^ r_wk[j];
                                end
                                r_state <= ST_RND_RD;
                            end
                            MODE_DEC: begin
                                for (int j = 0; j < 4; j++) begin
                                    r_in[j] <= in_w[j];
                                    r_w[j]  <= in_w[j] ^ r_wk[4 + j];
                                end
                                r_state <= ST_RND_RD;
                            end
                            default: begin
                                r_state <= ST_FINISH;
                            end
                        endcase
                    end
                end
                // Fill the list with 0..n-1.
                ST_INIT: begin
                    r_cnt <= r_cnt + 9'd1;
                    if (r_cnt == r_n - 9'd1) begin
                        r_state <= ST_DRAW;
                    end
                end
                // Draw a byte from the LFSR and start the modulo.
                ST_DRAW: begin
                    r_lfsr  <= lfsr_step8(r_lfsr);
                    r_byte  <= 8'(lfsr_step8(r_lfsr) & 32'h000000FF);
                    r_acc   <= 9'd0;
                    r_cnt   <= 9'd0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_acc  <= acc_nx;
                    r_byte <= {r_byte[6:0], 1'b0};
                    r_cnt  <= r_cnt + 9'd1;
                    if (r_cnt == 9'd7) begin
                        r_pick  <= acc_nx[7:0];
                        r_state <= ST_PRD;
                    end
                end
                ST_PRD: begin
                    r_state <= ST_PWR;
                end
                // Store the picked entry, then close the gap in the list.
                ST_PWR: begin
                    if (r_to_perm) begin
                        r_perm[r_i[2:0]] <= list_rdata[2:0];
                    end
                    r_k <= r_pick;
                    if ({1'b0, r_pick} + 9'd1 < rem) begin
                        r_state <= ST_SRD;
                    end else begin
                        r_i     <= i_nx;
                        r_state <= (i_nx == r_n) ? ST_FINISH : ST_DRAW;
                    end
                end
                ST_SRD: begin
                    r_state <= ST_SWR;
                end
                ST_SWR: begin
                    r_k <= k_nx[7:0];
                    if (k_nx + 9'd1 < rem) begin
                        r_state <= ST_SRD;
                    end else begin
                        r_i     <= i_nx;
                        r_state <= (i_nx == r_n) ? ST_FINISH : ST_DRAW;
                    end
                end
                ST_RND_RD: begin
                    r_state <= ST_RND_EX;
                end
                // Finish a round; the last round keeps the halves in place.
                ST_RND_EX: begin
                    if (r_round == RKAW'(NUM_ROUNDS - 1)) begin
                        if (r_dec) begin
                            r_res[0] <= t0 ^ r_wk[0] ^ r_chain[0];
                            r_res[1] <= t1 ^ r_wk[1] ^ r_chain[1];
                            r_res[2] <= r_w[2] ^ r_wk[2] ^ r_chain[2];
                            r_res[3] <= r_w[3] ^ r_wk[3] ^ r_chain[3];
                            for (int j = 0; j < 4; j++) begin
                                r_chain[j] <= r_in[j];
                            end
                        end else begin
                            r_res[0]   <= t0 ^ r_wk[4];
                            r_res[1]   <= t1 ^ r_wk[5];
                            r_res[2]   <= r_w[2] ^ r_wk[6];
                            r_res[3]   <= r_w[3] ^ r_wk[7];
                            r_chain[0] <= t0 ^ r_wk[4];
                            r_chain[1] <= t1 ^ r_wk[5];
                            r_chain[2] <= r_w[2] ^ r_wk[6];
                            r_chain[3] <= r_w[3] ^ r_wk[7];
                        end
                        r_state <= ST_FINISH;
                    end else begin
                        r_w[0]  <= r_w[2];
                        r_w[1]  <= r_w[3];
                        r_w[2]  <= t0;
                        r_w[3]  <= t1;
                        r_round <= r_round + RKAW'(1);
                        r_state <= ST_RND_RD;
                    end
                end
                // Hand the result to the output register once it is free.
                ST_FINISH: begin
                    if (out_slot) begin
                        for (int j = 0; j < 4; j++) begin
                            r_out[j] <= r_res[j];
                        end
                        r_status    <= r_res_status;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word0 = r_out[0];
    assign o_out_word1 = r_out[1];
    assign o_out_word2 = r_out[2];
    assign o_out_word3 = r_out[3];
    assign o_status    = r_status;
endmodule

// ===== rtl/fbc_checker.sv =====
// Port-level checker for the Feistel CBC block, bound to the top level.
// Depends on feistel_block_cipher_cbc_macros.svh.
`include "feistel_block_cipher_cbc_macros.svh"

module fbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_out_word0,
    input logic [31:0] o_out_word1,
    input logic [31:0] o_out_word2,
    input logic [31:0] o_out_word3,
    input logic        o_status
);
    logic out_zero;
    assign out_zero = (o_out_word0 == 32'd0) && (o_out_word1 == 32'd0)
                      && (o_out_word2 == 32'd0) && (o_out_word3 == 32'd0);

    // A stalled result holds its first word and its status.
    `FBC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_word0) && $stable(o_status))
    // One item at a time: no second transfer right after one.
    `FBC_ASSERT_NEXT(a_one_item, i_in_valid && o_in_ready, !o_in_ready)
    // A rejected key load carries zero words.
    `FBC_ASSERT_NOW(a_status_zero, o_out_valid && o_status, out_zero)
endmodule

bind feistel_block_cipher_cbc fbc_checker u_fbc_checker (.*);
